// ----- design/arsq_pkg.sv -----
// ----------------------------------------------------------------------------
// arsq_pkg - shared types and constants for the retransmit slot queue
// Opcodes, register indexes, reset values, payload structs and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package arsq_pkg;

  localparam int unsigned SLOTS_DEF            = 8;
  localparam int unsigned MAX_PACKET_BYTES_DEF = 64;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 1'd1;

  localparam logic [15:0] ACK_WAIT_LIMIT_RST = 16'd100;
  localparam logic [7:0]  RETRY_LIMIT_RST    = 8'd3;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_ACK     = 3'd1;
  localparam logic [2:0] OP_TICK    = 3'd2;
  localparam logic [2:0] OP_TX_DONE = 3'd3;
  localparam logic [2:0] OP_POLL    = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] transaction_id;
    logic [6:0] packet_length;
  } req_t;

  typedef struct packed {
    logic       send_start;
    logic [2:0] send_slot;
    logic [6:0] send_length;
    logic       load_accepted;
    logic [2:0] load_slot;
    logic       ack_matched;
    logic       slot_discarded;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic scan_zero;
    logic scan_cur;
    logic step;
    logic load_write;
    logic ack_clear;
    logic tick;
    logic free_line;
    logic poll_begin;
    logic discard;
    logic send_sel;
    logic send_len;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       poll_ok;
    logic       cur_valid;
    logic       is_current;
    logic       retry_over;
    logic       id_match;
    logic       last;
    logic       out_busy;
  } status_t;

endpackage

// ----- design/arsq_req_if.sv -----
// ----------------------------------------------------------------------------
// arsq_req_if - request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface arsq_req_if;
  logic           valid;
  logic           ready;
  arsq_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/arsq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// arsq_rsp_if - result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface arsq_rsp_if;
  logic           valid;
  logic           ready;
  arsq_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/arsq_ctrl.sv -----
// ----------------------------------------------------------------------------
// arsq_ctrl - sequencer of the retransmit slot queue
// Decodes each request and walks the slot scans one slot per cycle.
// ----------------------------------------------------------------------------
module arsq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  arsq_pkg::status_t  status_i,
  output arsq_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DISPATCH  = 3'd1;
  localparam logic [2:0] S_LOAD_SCAN = 3'd2;
  localparam logic [2:0] S_ACK_RD    = 3'd3;
  localparam logic [2:0] S_ACK_CMP   = 3'd4;
  localparam logic [2:0] S_POLL_SCAN = 3'd5;
  localparam logic [2:0] S_POLL_LEN  = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.op)
          arsq_pkg::OP_LOAD: begin
            cmd_o.scan_cur = 1'b1;
            state_d        = S_LOAD_SCAN;
          end
          arsq_pkg::OP_ACK: begin
            cmd_o.scan_zero = 1'b1;
            state_d         = S_ACK_RD;
          end
          arsq_pkg::OP_TICK: begin
            cmd_o.tick = 1'b1;
            state_d    = S_DONE;
          end
          arsq_pkg::OP_TX_DONE: begin
            cmd_o.free_line = 1'b1;
            state_d         = S_DONE;
          end
          arsq_pkg::OP_POLL: begin
            if (status_i.poll_ok) begin
              cmd_o.poll_begin = 1'b1;
              cmd_o.scan_cur   = 1'b1;
              state_d          = S_POLL_SCAN;
            end else begin
              state_d = S_DONE;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_LOAD_SCAN: begin
        if (!status_i.cur_valid) begin
          cmd_o.load_write = 1'b1;
          state_d          = S_DONE;
        end else if (status_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      // read of the first id is in flight
      S_ACK_RD: state_d = S_ACK_CMP;
      S_ACK_CMP: begin
        if (status_i.id_match) begin
          cmd_o.ack_clear = 1'b1;
          state_d         = S_DONE;
        end else if (status_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_POLL_SCAN: begin
        if (status_i.cur_valid && status_i.is_current && status_i.retry_over) begin
          cmd_o.discard = 1'b1;
          cmd_o.step    = 1'b1;
        end else if (status_i.cur_valid) begin
          cmd_o.send_sel = 1'b1;
          state_d        = S_POLL_LEN;
        end else if (status_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_POLL_LEN: begin
        cmd_o.send_len = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a request is taken only from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> (state_q == S_DISPATCH))
    else $error("latch did not enter dispatch");

  // a result is only loaded out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == S_IDLE))
    else $error("result load did not return to idle");

  // apart from a discard, the last scan slot never steps further
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && !cmd_o.discard) |-> !status_i.last)
    else $error("scan stepped past last slot");

endmodule

// ----- design/arsq_dp.sv -----
// ----------------------------------------------------------------------------
// arsq_dp - datapath of the retransmit slot queue
// Slot store, valid bits, link state, scan pointer and result registers.
// ----------------------------------------------------------------------------
module arsq_dp #(
  parameter int unsigned SLOTS            = arsq_pkg::SLOTS_DEF,
  parameter int unsigned MAX_PACKET_BYTES = arsq_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [arsq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [arsq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  arsq_pkg::req_t                      req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output arsq_pkg::rsp_t                      out_data_o,
  input  arsq_pkg::cmd_t                      cmd_i,
  output arsq_pkg::status_t                   status_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PACKET_BYTES);

  // configuration
  logic [15:0] ack_wait_limit_q;
  logic [7:0]  retry_limit_q;

  // latched request
  logic [2:0] op_q;
  logic [7:0] tid_q;
  logic [6:0] len_q;

  // link state
  logic [SLOTS-1:0] valid_q;
  logic [IDX_W-1:0] cur_q;
  logic [15:0]      wait_q;
  logic             ack_seen_q;
  logic [7:0]       retry_q;
  logic             line_free_q;

  // scan pointer
  logic [IDX_W-1:0] c_q, c_next, i_q, rd_addr;

  // slot store
  logic [7:0] id_mem  [SLOTS];
  logic [6:0] len_mem [SLOTS];
  logic [7:0] rd_id_q;
  logic [6:0] rd_len_q;

  logic [7:0]       retry_inc;
  logic [6:0]       len_clamped;
  logic [IDX_W+2:0] c_ext;

  arsq_pkg::rsp_t res_q, out_q;
  logic           out_valid_q;

  assign c_next      = (c_q == LAST_IDX) ? '0 : c_q + 1'b1;
  assign rd_addr     = cmd_i.step ? c_next : c_q;
  assign retry_inc   = (retry_q == 8'hFF) ? retry_q : retry_q + 8'd1;
  assign len_clamped = ({1'b0, len_q} > MAX_LEN) ? MAX_LEN[6:0] : len_q;
  assign c_ext       = {3'b000, c_q};

  always_comb begin
    status_o            = '0;
    status_o.op         = op_q;
    status_o.poll_ok    = line_free_q && !((wait_q < ack_wait_limit_q) && !ack_seen_q);
    status_o.cur_valid  = valid_q[c_q];
    status_o.is_current = (c_q == cur_q);
    status_o.retry_over = (retry_inc > retry_limit_q);
    status_o.id_match   = valid_q[c_q] && (rd_id_q == tid_q);
    status_o.last       = (i_q == LAST_IDX);
    status_o.out_busy   = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_wait_limit_q <= arsq_pkg::ACK_WAIT_LIMIT_RST;
      retry_limit_q    <= arsq_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        arsq_pkg::CFG_ACK_WAIT_LIMIT: ack_wait_limit_q <= cfg_data_i[15:0];
        arsq_pkg::CFG_RETRY_LIMIT:    retry_limit_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= req_i.opcode;
      tid_q <= req_i.transaction_id;
      len_q <= req_i.packet_length;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_write) begin
      id_mem[c_q]  <= tid_q;
      len_mem[c_q] <= len_clamped;
    end
    rd_id_q  <= id_mem[rd_addr];
    rd_len_q <= len_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
      i_q <= '0;
    end else if (cmd_i.scan_zero) begin
      c_q <= '0;
      i_q <= '0;
    end else if (cmd_i.scan_cur) begin
      c_q <= cur_q;
      i_q <= '0;
    end else if (cmd_i.step) begin
      c_q <= c_next;
      i_q <= i_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      cur_q       <= '0;
      wait_q      <= '0;
      ack_seen_q  <= 1'b0;
      retry_q     <= '0;
      line_free_q <= 1'b1;
    end else begin
      if (cmd_i.load_write) begin
        valid_q[c_q] <= 1'b1;
      end
      if (cmd_i.ack_clear) begin
        valid_q[c_q] <= 1'b0;
        if (c_q == cur_q) begin
          ack_seen_q <= 1'b1;
          wait_q     <= '0;
        end
      end
      if (cmd_i.tick && (wait_q != 16'hFFFF)) begin
        wait_q <= wait_q + 16'd1;
      end
      if (cmd_i.free_line) begin
        line_free_q <= 1'b1;
      end
      if (cmd_i.poll_begin) begin
        ack_seen_q <= 1'b0;
        wait_q     <= '0;
      end
      if (cmd_i.discard) begin
        retry_q      <= '0;
        valid_q[c_q] <= 1'b0;
      end
      if (cmd_i.send_sel) begin
        if (c_q == cur_q) begin
          retry_q <= retry_inc;
        end
        cur_q       <= c_q;
        line_free_q <= 1'b0;
      end
    end
  end

  // result under construction
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      res_q <= '0;
    end else begin
      if (cmd_i.load_write) begin
        res_q.load_accepted <= 1'b1;
        res_q.load_slot     <= c_ext[2:0];
      end
      if (cmd_i.ack_clear) begin
        res_q.ack_matched <= 1'b1;
      end
      if (cmd_i.discard) begin
        res_q.slot_discarded <= 1'b1;
      end
      if (cmd_i.send_sel) begin
        res_q.send_start <= 1'b1;
        res_q.send_slot  <= c_ext[2:0];
      end
      if (cmd_i.send_len) begin
        res_q.send_length <= rd_len_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the line is only taken by a send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(line_free_q) |-> $past(cmd_i.send_sel))
    else $error("line taken without a send");

  // a discard restarts the shared retry count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.discard |=> (retry_q == 8'd0))
    else $error("retry count not cleared on discard");

  // a loaded slot is valid afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_write |=> valid_q[$past(c_q)])
    else $error("loaded slot not valid");

  // a send result leaves the line busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && res_q.send_start) |-> !line_free_q)
    else $error("send reported with line free");

endmodule

// ----- design/ack_retransmit_slot_queue.sv -----
// ----------------------------------------------------------------------------
// ack_retransmit_slot_queue - transmit slot manager for an acked link
// Holds packet descriptors in slots, matches acks and picks what to send.
// ----------------------------------------------------------------------------
// usage
//   req_i carries one request (opcode, transaction id, packet length); each
//   accepted request gives exactly one result on rsp_o, in order.
//   cfg_we_i/cfg_index_i/cfg_data_i write ack_wait_limit (index 0) and
//   retry_limit (index 1); write them only while no request is in flight.
//   steps from request to result register:
//     tick, transmit done, unknown opcode, blocked poll: straight to done
//     load: probes slots one by one from the current slot for a free one
//     ack: reads slot ids from the slot store one by one from slot 0
//     poll: probes slots from the current slot, then reads the length
//   one request is in work at a time; the slot scan and the single read
//   port of the slot store set how long each request takes.
//   reset empties all slots, frees the line and clears the counters; the
//   registers return to 100 and 3.
//   a stalled result waits in the output register; the next request is
//   still taken and worked, and its result waits until the old one leaves.
// ----------------------------------------------------------------------------
module ack_retransmit_slot_queue #(
  parameter int unsigned SLOTS            = arsq_pkg::SLOTS_DEF,
  parameter int unsigned MAX_PACKET_BYTES = arsq_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [arsq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [arsq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  arsq_req_if.sink                        req_i,
  arsq_rsp_if.source                      rsp_o
);

  arsq_pkg::cmd_t    cmd;
  arsq_pkg::status_t status;

  arsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  arsq_dp #(
    .SLOTS            (SLOTS),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_i.data),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (rsp_o.data),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ----- tb/sv/ack_retransmit_slot_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_retransmit_slot_queue_tb - self-checking bench for the slot queue
// Sends loads, acks, ticks, transmit-done and polls over the request channel.
// A behavioral slot model predicts each result, and every result is compared
// field by field. Both channels stall at random, and the limits change
// between phases, the extremes among them.
// ----------------------------------------------------------------------------
module ack_retransmit_slot_queue_tb;

  localparam int unsigned SETTLE_CYC  = arsq_pkg::SLOTS_DEF + 4;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 315;

  localparam logic [2:0]  OP_RSVD_A       = 3'd5;
  localparam logic [2:0]  OP_RSVD_B       = 3'd6;
  localparam logic [2:0]  OP_RSVD_C       = 3'd7;
  localparam logic [15:0] WAIT_MAX        = 16'hFFFF;
  localparam logic [7:0]  RETRY_CAP       = 8'hFF;
  localparam logic [7:0]  RETRY_LIMIT_MAX = 8'd254;

  // behavioral copy of the slot store, link state and limits
  class slot_queue_board;
    bit             slot_used [arsq_pkg::SLOTS_DEF];
    logic [7:0]     slot_tid  [arsq_pkg::SLOTS_DEF];
    logic [6:0]     slot_len  [arsq_pkg::SLOTS_DEF];
    int unsigned    cur_slot;
    logic [15:0]    wait_ticks;
    bit             ack_hit;
    logic [7:0]     resend_cnt;
    bit             line_idle;
    logic [15:0]    ack_wait_limit;
    logic [7:0]     retry_limit;
    arsq_pkg::rsp_t due_results [$];

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      cur_slot       = 0;
      wait_ticks     = '0;
      ack_hit        = 1'b0;
      resend_cnt     = '0;
      line_idle      = 1'b1;
      ack_wait_limit = arsq_pkg::ACK_WAIT_LIMIT_RST;
      retry_limit    = arsq_pkg::RETRY_LIMIT_RST;
    endfunction

    function void set_limits(logic [15:0] wait_lim, logic [7:0] retry_lim);
      ack_wait_limit = wait_lim;
      retry_limit    = retry_lim;
    endfunction

    function int unsigned wrap_next(int unsigned s);
      return (s + 1 >= arsq_pkg::SLOTS_DEF) ? 0 : s + 1;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void apply_request(arsq_pkg::req_t r);
      arsq_pkg::rsp_t res;
      int unsigned    c;
      res = '0;
      case (r.opcode)
        arsq_pkg::OP_LOAD: begin
          c = cur_slot;
          for (int i = 0; i < arsq_pkg::SLOTS_DEF; i++) begin
            if (!slot_used[c]) begin
              slot_used[c] = 1'b1;
              slot_tid[c]  = r.transaction_id;
              slot_len[c]  = (r.packet_length > arsq_pkg::MAX_PACKET_BYTES_DEF) ?
                             7'(arsq_pkg::MAX_PACKET_BYTES_DEF) : r.packet_length;
              res.load_accepted = 1'b1;
              res.load_slot     = c[2:0];
              break;
            end
            c = wrap_next(c);
          end
        end
        arsq_pkg::OP_ACK: begin
          // lowest slot holding the id wins
          for (int i = 0; i < arsq_pkg::SLOTS_DEF; i++) begin
            if (slot_used[i] && slot_tid[i] == r.transaction_id) begin
              if (i == cur_slot) begin
                ack_hit    = 1'b1;
                wait_ticks = '0;
              end
              slot_used[i]    = 1'b0;
              res.ack_matched = 1'b1;
              break;
            end
          end
        end
        arsq_pkg::OP_TICK: begin
          if (wait_ticks != WAIT_MAX) wait_ticks++;
        end
        arsq_pkg::OP_TX_DONE: begin
          line_idle = 1'b1;
        end
        arsq_pkg::OP_POLL: begin
          if (line_idle && !(wait_ticks < ack_wait_limit && !ack_hit)) begin
            ack_hit    = 1'b0;
            wait_ticks = '0;
            c = cur_slot;
            for (int i = 0; i < arsq_pkg::SLOTS_DEF; i++) begin
              if (slot_used[c]) begin
                // the retry count is shared, only a discard clears it
                if (c == cur_slot) begin
                  if (resend_cnt != RETRY_CAP) resend_cnt++;
                  if (resend_cnt > retry_limit) begin
                    resend_cnt         = '0;
                    slot_used[c]       = 1'b0;
                    res.slot_discarded = 1'b1;
                    c = wrap_next(c);
                    continue;
                  end
                end
                res.send_start  = 1'b1;
                res.send_slot   = c[2:0];
                res.send_length = slot_len[c];
                cur_slot        = c;
                line_idle       = 1'b0;
                break;
              end
              c = wrap_next(c);
            end
          end
        end
        default: ;
      endcase
      due_results.push_back(res);
    endfunction

    function bit check_result(arsq_pkg::rsp_t got, output string note);
      arsq_pkg::rsp_t want;
      note = "";
      if (due_results.size() == 0) begin
        note = $sformatf("result %h with no request pending", got);
        return 1'b0;
      end
      want = due_results.pop_front();
      if (got.send_start !== want.send_start)
        note = {note, $sformatf(" send_start %h/%h", got.send_start, want.send_start)};
      if (got.send_slot !== want.send_slot)
        note = {note, $sformatf(" send_slot %h/%h", got.send_slot, want.send_slot)};
      if (got.send_length !== want.send_length)
        note = {note, $sformatf(" send_length %h/%h", got.send_length, want.send_length)};
      if (got.load_accepted !== want.load_accepted)
        note = {note, $sformatf(" load_accepted %h/%h", got.load_accepted,
                                want.load_accepted)};
      if (got.load_slot !== want.load_slot)
        note = {note, $sformatf(" load_slot %h/%h", got.load_slot, want.load_slot)};
      if (got.ack_matched !== want.ack_matched)
        note = {note, $sformatf(" ack_matched %h/%h", got.ack_matched, want.ack_matched)};
      if (got.slot_discarded !== want.slot_discarded)
        note = {note, $sformatf(" slot_discarded %h/%h", got.slot_discarded,
                                want.slot_discarded)};
      if (note != "") note = {"got/exp:", note};
      return note == "";
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [arsq_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [arsq_pkg::CFG_DATA_W-1:0] cfg_data_i;

  arsq_req_if req_bus ();
  arsq_rsp_if rsp_bus ();

  slot_queue_board board;
  int unsigned     error_count   = 0;
  int unsigned     stall_cycles  = 0;
  int unsigned     items_sent    = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;

  ack_retransmit_slot_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // result checks and request bookkeeping, on pre-edge values
  always @(posedge clk_i) begin
    string note;
    if (rsp_bus.valid && rsp_bus.ready) begin
      if (!board.check_result(rsp_bus.data, note)) report_mismatch(note);
    end
    if (req_bus.valid && req_bus.ready) board.apply_request(req_bus.data);
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] pick_tid();
    // mostly a small pool so acks find their packets
    return ($urandom_range(99) < 75) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
  endfunction

  function automatic logic [6:0] pick_len();
    return ($urandom_range(99) < 60) ? 7'($urandom_range(arsq_pkg::MAX_PACKET_BYTES_DEF))
                                     : 7'($urandom_range(127));
  endfunction

  task automatic send_req(input logic [2:0] op, input logic [7:0] tid,
                          input logic [6:0] len);
    arsq_pkg::req_t rq;
    rq.opcode         = op;
    rq.transaction_id = tid;
    rq.packet_length  = len;
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= rq;
    do begin
      @(posedge clk_i);
    end while (!req_bus.ready);
    items_sent++;
  endtask

  task automatic send_any(input logic [2:0] op);
    send_req(op, 8'($urandom_range(255)), 7'($urandom_range(127)));
  endtask

  // drain all results, then let the block go quiet
  task automatic settle();
    req_bus.valid <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (board.pending() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [15:0] wait_lim, input logic [7:0] retry_lim);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= arsq_pkg::CFG_ACK_WAIT_LIMIT;
    cfg_data_i  <= wait_lim;
    @(posedge clk_i);
    cfg_index_i <= arsq_pkg::CFG_RETRY_LIMIT;
    cfg_data_i  <= {8'h00, retry_lim};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_limits(wait_lim, retry_lim);
  endtask

  task automatic random_request();
    int unsigned pick;
    logic [7:0]  tid;
    logic [6:0]  len;
    pick = $urandom_range(99);
    tid  = pick_tid();
    len  = pick_len();
    if (pick < 22)      send_req(arsq_pkg::OP_LOAD, tid, len);
    else if (pick < 37) send_req(arsq_pkg::OP_ACK, tid, len);
    else if (pick < 60) send_req(arsq_pkg::OP_TICK, tid, len);
    else if (pick < 75) send_req(arsq_pkg::OP_TX_DONE, tid, len);
    else if (pick < 95) send_req(arsq_pkg::OP_POLL, tid, len);
    else                send_req(3'($urandom_range(OP_RSVD_C, OP_RSVD_A)), tid, len);
  endtask

  // one transmit cycle of the link: line frees, timer runs, poll, maybe ack
  task automatic link_round(input logic [15:0] wait_lim);
    if ($urandom_range(99) < 30) send_req(arsq_pkg::OP_LOAD, pick_tid(), pick_len());
    send_req(arsq_pkg::OP_TX_DONE, pick_tid(), pick_len());
    repeat ($urandom_range(32'(wait_lim) + 1, 32'(wait_lim) - 1))
      send_req(arsq_pkg::OP_TICK, pick_tid(), pick_len());
    send_req(arsq_pkg::OP_POLL, pick_tid(), pick_len());
    if ($urandom_range(99) < 50) send_req(arsq_pkg::OP_ACK, pick_tid(), pick_len());
  endtask

  task automatic random_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                              input logic [15:0] wait_lim, input logic [7:0] retry_lim);
    int unsigned goal;
    settle();
    write_limits(wait_lim, retry_lim);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 35) link_round(wait_lim);
      else random_request();
    end
  endtask

  initial begin
    board = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= arsq_pkg::CFG_ACK_WAIT_LIMIT;
    cfg_data_i    <= '0;
    req_bus.valid <= 1'b0;
    req_bus.data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    settle();
    write_limits(16'd2, 8'd1);
    send_req(arsq_pkg::OP_POLL, 8'h00, 7'd0);       // still waiting on the timer
    send_req(arsq_pkg::OP_TICK, 8'hFF, 7'h7F);
    send_req(arsq_pkg::OP_TICK, 8'h00, 7'd0);
    send_req(arsq_pkg::OP_POLL, 8'hFF, 7'h7F);      // nothing loaded yet
    send_req(arsq_pkg::OP_LOAD, 8'h00, 7'd0);       // zero-length packet
    send_req(arsq_pkg::OP_LOAD, 8'hFF, 7'h7F);      // longer than the max, gets clipped
    send_req(arsq_pkg::OP_LOAD, 8'hA5, 7'd64);
    send_req(arsq_pkg::OP_LOAD, 8'h5A, 7'd1);
    send_req(arsq_pkg::OP_ACK, 8'h33, 7'h55);       // id not in any slot
    send_req(OP_RSVD_A, 8'hFF, 7'h7F);
    send_req(OP_RSVD_B, 8'h00, 7'd0);
    send_req(OP_RSVD_C, 8'h5A, 7'h2A);
    send_req(arsq_pkg::OP_TICK, 8'h12, 7'h40);
    send_req(arsq_pkg::OP_TICK, 8'h34, 7'h3F);
    send_req(arsq_pkg::OP_POLL, 8'h56, 7'h11);      // first send
    send_req(arsq_pkg::OP_POLL, 8'h78, 7'h22);      // line still busy
    send_req(arsq_pkg::OP_TX_DONE, 8'h9A, 7'h33);
    send_req(arsq_pkg::OP_ACK, 8'h00, 7'h44);       // acks the current slot
    send_req(arsq_pkg::OP_POLL, 8'hBC, 7'h66);      // ack seen, no wait needed
    send_req(arsq_pkg::OP_TX_DONE, 8'hDE, 7'h77);
    send_req(arsq_pkg::OP_TICK, 8'hF0, 7'h08);
    send_req(arsq_pkg::OP_TICK, 8'h0F, 7'h70);
    send_req(arsq_pkg::OP_POLL, 8'hC3, 7'h1C);      // resend limit hit, slot dropped
    repeat (7) send_any(arsq_pkg::OP_LOAD);         // last load finds every slot taken

    // the same slot resent until the shared count runs over the top limit
    settle();
    write_limits(16'd1, RETRY_LIMIT_MAX);
    repeat (260) begin
      send_any(arsq_pkg::OP_TX_DONE);
      send_any(arsq_pkg::OP_TICK);
      send_any(arsq_pkg::OP_POLL);
    end

    random_phase(15, 80, 16'd1, 8'd0);
    random_phase(80, 15, 16'($urandom_range(8, 3)), 8'd2);
    random_phase(0, 0, 16'($urandom_range(12, 2)), 8'($urandom_range(6, 1)));
    settle();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
